// File: hw/rtl/crtt_pkg.sv
// ----------------------------------------------------------------------------
// crtt_pkg
// Shared types and constants for the trail tessellator: weight format,
// issue descriptor and control point ordering of the three segments.
// ----------------------------------------------------------------------------
package crtt_pkg;

  // blend weights carry 10 fraction bits, range well inside 12 signed bits
  localparam int WEIGHT_FRAC = 10;
  localparam int WEIGHT_W    = 12;
  localparam int INDEX_W     = 5;
  localparam int NUM_PTS     = 4;
  localparam int NUM_AXES    = 3;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // segment codes, newest segment first
  typedef enum logic [1:0] {
    SEG_NEW = 2'd0,
    SEG_MID = 2'd1,
    SEG_OLD = 2'd2
  } seg_t;

  // one vertex issued into the blend pipeline
  typedef struct packed {
    logic               valid;
    seg_t               seg;
    logic [INDEX_W-1:0] vertex_index;
    logic               last;
  } issue_t;

  // history age (0 newest) used at blend position p of a segment
  function automatic logic [1:0] seg_age(input seg_t seg, input logic [1:0] p);
    logic [1:0] age;
    case (seg)
      SEG_NEW: age = (p == 2'd0) ? 2'd0 : 2'(p - 2'd1);
      SEG_MID: age = p;
      SEG_OLD: age = (p == 2'd3) ? 2'd3 : 2'(p + 2'd1);
      default: age = p;
    endcase
    return age;
  endfunction

endpackage

// File: hw/rtl/crtt_seq.sv
// ----------------------------------------------------------------------------
// crtt_seq
// Vertex sequencer: walks the vertex positions of one item, maps each to a
// segment and step, and decides when the next input transfer is taken.
// ----------------------------------------------------------------------------
module crtt_seq #(
  parameter int SEGMENT_STEPS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  advance,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  output logic                                  accept,
  output crtt_pkg::issue_t                      iss,
  output logic [$clog2(SEGMENT_STEPS+1)-1:0]    step
);

  localparam int N_VERT = 3 * SEGMENT_STEPS + 6;
  localparam int KW     = $clog2(N_VERT);
  localparam int JW     = $clog2(SEGMENT_STEPS + 1);

  localparam logic [KW-1:0] K_S   = KW'(SEGMENT_STEPS);
  localparam logic [KW-1:0] K_C1  = KW'(SEGMENT_STEPS + 1);
  localparam logic [KW-1:0] K_S1  = KW'(SEGMENT_STEPS + 2);
  localparam logic [KW-1:0] K_C2  = KW'(2 * SEGMENT_STEPS + 3);
  localparam logic [KW-1:0] K_S2  = KW'(2 * SEGMENT_STEPS + 4);
  localparam logic [KW-1:0] K_END = KW'(3 * SEGMENT_STEPS + 5);

  logic            run_r, run_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            last_k;
  logic            in_ready;
  logic            issue_valid;
  logic [KW-1:0]   kd;
  logic [KW+4:0]   kx;
  crtt_pkg::seg_t  seg_sel;

  // handshake: idle takes a transfer at once, a run hands over on its last vertex
  assign last_k      = (k_r == K_END);
  assign in_ready    = !run_r || (advance && last_k);
  assign in_stall    = !in_ready;
  assign accept      = in_valid && in_ready;
  assign issue_valid = run_r && advance;

  // run state
  always_comb begin
    run_nxt = run_r;
    k_nxt   = k_r;
    if (accept) begin
      run_nxt = 1'b1;
      k_nxt   = '0;
    end else if (issue_valid) begin
      if (last_k) begin
        run_nxt = 1'b0;
        k_nxt   = '0;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      k_r   <= '0;
    end else begin
      run_r <= run_nxt;
      k_r   <= k_nxt;
    end
  end

  // position to segment and step; the plain control points are blends at
  // a segment end
  always_comb begin
    seg_sel = crtt_pkg::SEG_OLD;
    kd      = K_S;
    if (k_r <= K_S) begin
      seg_sel = crtt_pkg::SEG_NEW;
      kd      = k_r;
    end else if (k_r == K_C1) begin
      seg_sel = crtt_pkg::SEG_MID;
      kd      = '0;
    end else if (k_r < K_C2) begin
      seg_sel = crtt_pkg::SEG_MID;
      kd      = k_r - K_S1;
    end else if (k_r == K_C2) begin
      seg_sel = crtt_pkg::SEG_OLD;
      kd      = '0;
    end else if (k_r < K_END) begin
      seg_sel = crtt_pkg::SEG_OLD;
      kd      = k_r - K_S2;
    end
  end

  assign kx               = {5'b0, k_r};
  assign step             = kd[JW-1:0];
  assign iss.seg          = seg_sel;
  assign iss.valid        = issue_valid;
  assign iss.vertex_index = kx[crtt_pkg::INDEX_W-1:0];
  assign iss.last         = last_k;

endmodule

// File: hw/rtl/crtt_lane.sv
// ----------------------------------------------------------------------------
// crtt_lane
// One coordinate blend: four weighted products in a register stage, then
// sum, arithmetic shift and saturation into the result register.
// ----------------------------------------------------------------------------
module crtt_lane #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          advance,
  input  logic signed [COORD_WIDTH-1:0] pts [crtt_pkg::NUM_PTS],
  input  crtt_pkg::weight_t             wts [crtt_pkg::NUM_PTS],
  output logic signed [COORD_WIDTH-1:0] coord
);

  localparam int WW = crtt_pkg::WEIGHT_W;
  localparam int PW = COORD_WIDTH + WW;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = SW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  logic signed [PW-1:0]          prod_r   [crtt_pkg::NUM_PTS];
  logic signed [PW-1:0]          prod_nxt [crtt_pkg::NUM_PTS];
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          q;
  logic signed [COORD_WIDTH-1:0] coord_r, coord_nxt;

  // products, operands sign-extended to the product width
  always_comb begin
    for (int p = 0; p < crtt_pkg::NUM_PTS; p++) begin
      prod_nxt[p] = $signed({{WW{pts[p][COORD_WIDTH-1]}}, pts[p]})
                  * $signed({{COORD_WIDTH{wts[p][WW-1]}}, wts[p]});
    end
  end

  // sum, floor shift and clamp to the coordinate range
  always_comb begin
    sum = $signed({{2{prod_r[0][PW-1]}}, prod_r[0]})
        + $signed({{2{prod_r[1][PW-1]}}, prod_r[1]})
        + $signed({{2{prod_r[2][PW-1]}}, prod_r[2]})
        + $signed({{2{prod_r[3][PW-1]}}, prod_r[3]});
    q = sum >>> crtt_pkg::WEIGHT_FRAC;
    if (q > HI) begin
      coord_nxt = HI[COORD_WIDTH-1:0];
    end else if (q < LO) begin
      coord_nxt = LO[COORD_WIDTH-1:0];
    end else begin
      coord_nxt = q[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < crtt_pkg::NUM_PTS; p++) begin
        prod_r[p] <= prod_nxt[p];
      end
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

// File: hw/rtl/catmull_rom_trail_tessellator_core.sv
// ----------------------------------------------------------------------------
// catmull_rom_trail_tessellator_core
// Keeps four control points per edge and tessellates both swept edges into
// a Catmull-Rom vertex strip, one vertex pair per output transfer.
// ----------------------------------------------------------------------------
// first vertex of an item: sequencer run state, then product and result registers
// throughput: one vertex per cycle while out_stall is low, 3*SEGMENT_STEPS+6 vertices
//   per item (30 at default), set by the single vertex output channel
// the next input transfer is taken in the cycle the last vertex is issued
// reset: control point history cleared to zero, pipeline emptied
module catmull_rom_trail_tessellator_core #(
  parameter int SEGMENT_STEPS = 8,
  parameter int COORD_WIDTH   = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [4:0]                    out_vertex_index,
  output logic signed [COORD_WIDTH-1:0] out_start_edge_x,
  output logic signed [COORD_WIDTH-1:0] out_start_edge_y,
  output logic signed [COORD_WIDTH-1:0] out_start_edge_z,
  output logic signed [COORD_WIDTH-1:0] out_end_edge_x,
  output logic signed [COORD_WIDTH-1:0] out_end_edge_y,
  output logic signed [COORD_WIDTH-1:0] out_end_edge_z,
  output logic                          out_last_vertex
);

  localparam int JW   = $clog2(SEGMENT_STEPS + 1);
  localparam int NP   = crtt_pkg::NUM_PTS;
  localparam int NA   = crtt_pkg::NUM_AXES;
  localparam longint Sv = SEGMENT_STEPS;
  localparam longint D  = 2 * Sv * Sv * Sv;
  localparam longint Sc = 64'sd1 <<< crtt_pkg::WEIGHT_FRAC;

  logic                          advance;
  logic                          accept;
  crtt_pkg::issue_t              iss;
  logic [JW-1:0]                 step;

  logic signed [COORD_WIDTH-1:0] st_hist_r [NP][NA];
  logic signed [COORD_WIDTH-1:0] en_hist_r [NP][NA];
  logic signed [COORD_WIDTH-1:0] st_in [NA];
  logic signed [COORD_WIDTH-1:0] en_in [NA];
  logic signed [COORD_WIDTH-1:0] st_pts [NA][NP];
  logic signed [COORD_WIDTH-1:0] en_pts [NA][NP];
  logic signed [COORD_WIDTH-1:0] st_res [NA];
  logic signed [COORD_WIDTH-1:0] en_res [NA];

  crtt_pkg::weight_t             wtab [SEGMENT_STEPS+1][NP];
  crtt_pkg::weight_t             wsel [NP];

  logic                          mid_valid_r;
  logic [4:0]                    mid_idx_r;
  logic                          mid_last_r;
  logic                          out_valid_r;
  logic [4:0]                    out_idx_r;
  logic                          out_last_r;

  // pipeline moves when the result register is free or being drained
  assign advance = !out_valid_r || !out_stall;

  crtt_seq #(
    .SEGMENT_STEPS (SEGMENT_STEPS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .accept   (accept),
    .iss      (iss),
    .step     (step)
  );

  // blend weight table, rounded to nearest at elaboration
  genvar gj;
  generate
    for (gj = 0; gj <= SEGMENT_STEPS; gj++) begin : g_wt
      localparam longint T  = gj;
      localparam longint N0 = (-T*T*T + 2*T*T*Sv - T*Sv*Sv) * Sc;
      localparam longint N1 = (3*T*T*T - 5*T*T*Sv + 2*Sv*Sv*Sv) * Sc;
      localparam longint N2 = (-3*T*T*T + 4*T*T*Sv + T*Sv*Sv) * Sc;
      localparam longint N3 = (T*T*T - T*T*Sv) * Sc;
      localparam longint R0 = (N0 >= 0) ? (N0 + D/2) / D : -((-N0 + D/2) / D);
      localparam longint R1 = (N1 >= 0) ? (N1 + D/2) / D : -((-N1 + D/2) / D);
      localparam longint R2 = (N2 >= 0) ? (N2 + D/2) / D : -((-N2 + D/2) / D);
      localparam longint R3 = (N3 >= 0) ? (N3 + D/2) / D : -((-N3 + D/2) / D);
      assign wtab[gj][0] = crtt_pkg::weight_t'(R0);
      assign wtab[gj][1] = crtt_pkg::weight_t'(R1);
      assign wtab[gj][2] = crtt_pkg::weight_t'(R2);
      assign wtab[gj][3] = crtt_pkg::weight_t'(R3);
    end
  endgenerate

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      wsel[p] = wtab[step][p];
    end
  end

  // control point history, aged on each input transfer
  assign st_in[0] = in_start_x;
  assign st_in[1] = in_start_y;
  assign st_in[2] = in_start_z;
  assign en_in[0] = in_end_x;
  assign en_in[1] = in_end_y;
  assign en_in[2] = in_end_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NP; a++) begin
        for (int c = 0; c < NA; c++) begin
          st_hist_r[a][c] <= '0;
          en_hist_r[a][c] <= '0;
        end
      end
    end else if (accept) begin
      for (int c = 0; c < NA; c++) begin
        for (int a = NP - 1; a > 0; a--) begin
          st_hist_r[a][c] <= st_hist_r[a-1][c];
          en_hist_r[a][c] <= en_hist_r[a-1][c];
        end
        st_hist_r[0][c] <= st_in[c];
        en_hist_r[0][c] <= en_in[c];
      end
    end
  end

  // pick the four control points of the current segment
  always_comb begin
    for (int c = 0; c < NA; c++) begin
      for (int p = 0; p < NP; p++) begin
        st_pts[c][p] = st_hist_r[crtt_pkg::seg_age(iss.seg, 2'(p))][c];
        en_pts[c][p] = en_hist_r[crtt_pkg::seg_age(iss.seg, 2'(p))][c];
      end
    end
  end

  // six coordinate blend lanes
  genvar gc;
  generate
    for (gc = 0; gc < NA; gc++) begin : g_lane
      crtt_lane #(
        .COORD_WIDTH (COORD_WIDTH)
      ) u_st (
        .clk     (clk),
        .advance (advance),
        .pts     (st_pts[gc]),
        .wts     (wsel),
        .coord   (st_res[gc])
      );
      crtt_lane #(
        .COORD_WIDTH (COORD_WIDTH)
      ) u_en (
        .clk     (clk),
        .advance (advance),
        .pts     (en_pts[gc]),
        .wts     (wsel),
        .coord   (en_res[gc])
      );
    end
  endgenerate

  // valid and tag registers alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      mid_valid_r <= iss.valid;
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mid_idx_r  <= iss.vertex_index;
      mid_last_r <= iss.last;
      out_idx_r  <= mid_idx_r;
      out_last_r <= mid_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_last_vertex  = out_last_r;
  assign out_start_edge_x = st_res[0];
  assign out_start_edge_y = st_res[1];
  assign out_start_edge_z = st_res[2];
  assign out_end_edge_x   = en_res[0];
  assign out_end_edge_y   = en_res[1];
  assign out_end_edge_z   = en_res[2];

endmodule

// File: hw/rtl/crtt_checker.sv
// ----------------------------------------------------------------------------
// crtt_checker
// Port-level checks of the vertex stream: ordering within a run, run end
// marking, output hold under stall and reset behavior.
// ----------------------------------------------------------------------------
module crtt_checker #(
  parameter int SEGMENT_STEPS = 8,
  parameter int COORD_WIDTH   = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [4:0]             out_vertex_index,
  input logic [COORD_WIDTH-1:0] out_start_edge_x,
  input logic                   out_last_vertex
);

  localparam logic [4:0] LAST_IDX = 5'(3 * SEGMENT_STEPS + 5);

  // a stalled vertex holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index)
      && $stable(out_start_edge_x) && $stable(out_last_vertex))
    else $error("stalled vertex changed");

  // within a run the next vertex follows at once with the next index
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_vertex |=>
      out_valid && (out_vertex_index == 5'($past(out_vertex_index) + 5'd1)))
    else $error("vertex run broken");

  // the run end marker sits on the final position
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_vertex |-> out_vertex_index == LAST_IDX)
    else $error("last vertex at wrong index");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind catmull_rom_trail_tessellator_core crtt_checker #(
  .SEGMENT_STEPS (SEGMENT_STEPS),
  .COORD_WIDTH   (COORD_WIDTH)
) u_crtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_vertex_index (out_vertex_index),
  .out_start_edge_x (out_start_edge_x),
  .out_last_vertex  (out_last_vertex)
);
